>>> rtl/ffha_pkg.sv
package ffha_pkg;

    localparam int POOL_BYTES   = 4096;
    localparam int HEADER_BYTES = 16;
    localparam int ADDR_W       = $clog2(POOL_BYTES);
    localparam int SIZE_W       = 12;
    localparam int POOL_W       = 13;
    localparam int SUM_W        = 14;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic STATUS_DONE  = 1'b0;
    localparam logic STATUS_NOFIT = 1'b1;

    typedef struct packed {
        logic              op;
        logic [11:0]       request_bytes;
        logic [11:0]       release_offset;
    } cmd_t;

    typedef struct packed {
        logic              status;
        logic [11:0]       payload_offset;
    } result_t;

    typedef struct packed {
        logic              free;
        logic [SIZE_W-1:0] size;
    } hdr_t;

    localparam int HDR_W = $bits(hdr_t);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CHECK,
        ST_MARK,
        ST_REL_WR
    } state_t;

endpackage

>>> rtl/ffha_ram.sv
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/ffha_walk.sv
module ffha_walk
    import ffha_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  cmd_t                  cmd,
    input  logic                  relayout,
    input  logic [POOL_W-1:0]     pool,
    output logic                  busy,
    output logic                  cfg_ready,
    output logic                  done,
    output result_t               result,
    output logic                  mem_we,
    output logic [ADDR_W-1:0]     mem_waddr,
    output hdr_t                  mem_wdata,
    output logic [ADDR_W-1:0]     mem_raddr,
    input  hdr_t                  mem_rdata
);

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   cur_reg, cur_next;
    logic [SIZE_W-1:0]   req_reg, req_next;
    logic                done_reg, done_next;
    result_t             res_reg, res_next;

    logic                fit;
    logic                split;
    logic [SUM_W-1:0]    next_hdr;
    logic [SUM_W-1:0]    split_hdr;
    logic [SUM_W-1:0]    split_limit;
    logic [SIZE_W-1:0]   rest_size;
    logic [ADDR_W-1:0]   rel_hdr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        req_reg <= req_next;
        res_reg <= res_next;
    end

    assign fit         = mem_rdata.free && (mem_rdata.size >= req_reg);
    assign next_hdr    = SUM_W'(cur_reg) + SUM_W'(HEADER_BYTES) + SUM_W'(mem_rdata.size);
    assign split_hdr   = SUM_W'(cur_reg) + SUM_W'(HEADER_BYTES) + SUM_W'(req_reg);
    assign split_limit = SUM_W'(req_reg) + SUM_W'(HEADER_BYTES);
    assign split       = (SUM_W'(mem_rdata.size) > split_limit)
                         && (split_hdr < SUM_W'(POOL_BYTES));
    assign rest_size   = SIZE_W'(SUM_W'(mem_rdata.size) - split_limit);
    assign rel_hdr     = ADDR_W'(cmd.release_offset - 12'(HEADER_BYTES));

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        req_next   = req_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = cur_reg;
        mem_wdata  = mem_rdata;
        mem_raddr  = cur_reg;

        case (state_reg)
            ST_INIT:
            begin
                mem_we         = 1'b1;
                mem_waddr      = '0;
                mem_wdata.free = 1'b1;
                mem_wdata.size = SIZE_W'(pool - POOL_W'(HEADER_BYTES));
                state_next     = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next = cmd.request_bytes;
                    res_next = '{status: STATUS_DONE, payload_offset: '0};
                    if (cmd.op == OP_ALLOC)
                    begin
                        cur_next   = '0;
                        mem_raddr  = '0;
                        state_next = ST_CHECK;
                    end
                    else if (cmd.release_offset >= 12'(HEADER_BYTES))
                    begin
                        cur_next   = rel_hdr;
                        mem_raddr  = rel_hdr;
                        state_next = ST_REL_WR;
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
            end
            ST_CHECK:
            begin
                if (fit)
                begin
                    res_next = '{status: STATUS_DONE,
                                 payload_offset: 12'(cur_reg + ADDR_W'(HEADER_BYTES))};
                    mem_we = 1'b1;
                    if (split)
                    begin
                        mem_waddr      = ADDR_W'(split_hdr);
                        mem_wdata.free = 1'b1;
                        mem_wdata.size = rest_size;
                        state_next     = ST_MARK;
                    end
                    else
                    begin
                        mem_waddr      = cur_reg;
                        mem_wdata.free = 1'b0;
                        mem_wdata.size = mem_rdata.size;
                        done_next      = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else if (next_hdr >= SUM_W'(pool))
                begin
                    res_next   = '{status: STATUS_NOFIT, payload_offset: '0};
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cur_next  = ADDR_W'(next_hdr);
                    mem_raddr = ADDR_W'(next_hdr);
                end
            end
            ST_MARK:
            begin
                mem_we         = 1'b1;
                mem_waddr      = cur_reg;
                mem_wdata.free = 1'b0;
                mem_wdata.size = req_reg;
                done_next      = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_REL_WR:
            begin
                mem_we         = 1'b1;
                mem_waddr      = cur_reg;
                mem_wdata.free = 1'b1;
                mem_wdata.size = mem_rdata.size;
                done_next      = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase

        if (relayout)
        begin
            state_next = ST_INIT;
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE) && !start;
    assign done      = done_reg;
    assign result    = res_reg;

endmodule

>>> rtl/first_fit_heap_allocator_unit.sv
// Allocate walks the block headers from offset 0; a split writes the new free header
// ahead of marking the chosen block used; release ignores offsets below 16, else frees a header.
// The result word is strobed on done in the first idle cycle after the command.
// The unit takes one command at a time and accepts no new command while busy.
// After reset, and after each pool size write, the unit is busy while it lays out the pool.
// Results cannot be stalled by the receiver.
module first_fit_heap_allocator_unit
    import ffha_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  cmd_t              cmd,
    output logic              done,
    output result_t           result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [POOL_W-1:0] cfg_data
);

    logic [POOL_W-1:0] pool_reg, pool_next;
    logic              cfg_wr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    hdr_t              mem_wdata;
    hdr_t              mem_rdata;

    assign cfg_wr = cfg_valid && cfg_ready;

    always_comb
    begin
        pool_next = pool_reg;
        if (cfg_wr)
        begin
            if (cfg_data < POOL_W'(HEADER_BYTES))
            begin
                pool_next = POOL_W'(HEADER_BYTES);
            end
            else if (cfg_data > POOL_W'(POOL_BYTES))
            begin
                pool_next = POOL_W'(POOL_BYTES);
            end
            else
            begin
                pool_next = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_reg <= POOL_W'(POOL_BYTES);
        end
        else
        begin
            pool_reg <= pool_next;
        end
    end

    ffha_walk u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .relayout  (cfg_wr),
        .pool      (pool_next),
        .busy      (busy),
        .cfg_ready (cfg_ready),
        .done      (done),
        .result    (result),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    ffha_ram #(
        .WIDTH (HDR_W),
        .DEPTH (POOL_BYTES)
    ) u_hdr_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

>>> rtl/ffha_checker.sv
module ffha_checker
    import ffha_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input cmd_t              cmd,
    input logic              done,
    input result_t           result,
    input logic              cfg_valid,
    input logic              cfg_ready,
    input logic [POOL_W-1:0] cfg_data
);

    logic accept;

    assign accept = start && !busy;

    // A result word is only ever shown once the unit has gone idle again.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while busy");

    a_nofit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == STATUS_NOFIT) |-> (result.payload_offset == '0))
        else $error("no-fit result carries an offset");

    a_rel_short: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.op == OP_RELEASE && cmd.release_offset < 12'(HEADER_BYTES))
        |=> (done && result.status == STATUS_DONE && result.payload_offset == '0))
        else $error("ignored release did not finish next cycle");

    a_rel_long: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.op == OP_RELEASE && cmd.release_offset >= 12'(HEADER_BYTES))
        |=> busy ##1 (done && result.status == STATUS_DONE && result.payload_offset == '0))
        else $error("release did not finish in two cycles");

    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !busy)
        else $error("configuration taken while busy");

endmodule

bind first_fit_heap_allocator_unit ffha_checker u_ffha_checker (.*);

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import ffha_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int TAIL_CYCLES = 300;

    class heap_tracker;
        logic [SIZE_W-1:0] blk_size [POOL_BYTES];
        bit                blk_free [POOL_BYTES];
        int unsigned       pool_limit;
        result_t           expected_results [$];
        int                mismatches;

        function new();
            mismatches = 0;
            lay_out(POOL_BYTES);
        endfunction

        function void lay_out(int unsigned bytes);
            pool_limit = bytes;
            if (pool_limit < HEADER_BYTES) pool_limit = HEADER_BYTES;
            if (pool_limit > POOL_BYTES) pool_limit = POOL_BYTES;
            foreach (blk_size[i])
            begin
                blk_size[i] = '0;
                blk_free[i] = 1'b0;
            end
            blk_size[0] = SIZE_W'(pool_limit - HEADER_BYTES);
            blk_free[0] = 1'b1;
        endfunction

        function result_t note_command(cmd_t c);
            result_t     r;
            int unsigned cur;
            int unsigned nxt;
            int unsigned req;
            int unsigned hdr;
            int unsigned nb;
            bit          settled;
            r.status = STATUS_DONE;
            r.payload_offset = '0;
            if (c.op == OP_RELEASE)
            begin
                if (c.release_offset >= HEADER_BYTES)
                begin
                    hdr = c.release_offset - HEADER_BYTES;
                    if (hdr < POOL_BYTES) blk_free[hdr] = 1'b1;
                end
            end
            else
            begin
                req = c.request_bytes;
                cur = 0;
                settled = 1'b0;
                while (!settled)
                begin
                    if (cur >= POOL_BYTES)
                    begin
                        r.status = STATUS_NOFIT;
                        settled = 1'b1;
                    end
                    else if (blk_free[cur] && blk_size[cur] >= req)
                    begin
                        settled = 1'b1;
                    end
                    else
                    begin
                        nxt = cur + HEADER_BYTES + blk_size[cur];
                        if (nxt >= pool_limit)
                        begin
                            r.status = STATUS_NOFIT;
                            settled = 1'b1;
                        end
                        else
                        begin
                            cur = nxt;
                        end
                    end
                end
                if (r.status == STATUS_DONE)
                begin
                    if (blk_size[cur] > req + HEADER_BYTES)
                    begin
                        nb = cur + HEADER_BYTES + req;
                        if (nb < POOL_BYTES)
                        begin
                            blk_size[nb] = SIZE_W'(blk_size[cur] - req - HEADER_BYTES);
                            blk_free[nb] = 1'b1;
                            blk_size[cur] = SIZE_W'(req);
                        end
                    end
                    blk_free[cur] = 1'b0;
                    r.payload_offset = 12'(cur + HEADER_BYTES);
                end
            end
            expected_results.push_back(r);
            return r;
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result word: status %0d payload_offset %0d",
                       got.status, got.payload_offset);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.payload_offset !== want.payload_offset)
            begin
                $error("payload_offset: expected %0d, got %0d",
                       want.payload_offset, got.payload_offset);
                mismatches++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    cmd_t              cmd;
    logic              done;
    result_t           result;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [POOL_W-1:0] cfg_data;

    heap_tracker sb = new();

    logic [11:0] live_offsets [$];
    logic [11:0] last_freed;
    int unsigned pool_now;
    int unsigned burst_left;
    bit          steady;
    int unsigned cycles;

    first_fit_heap_allocator_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done) sb.check_result(result);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("first_fit_heap_allocator_unit regression: fail");
            $finish;
        end
    end

    function automatic cmd_t make_cmd(logic op, int unsigned req, int unsigned rel);
        cmd_t c;
        c.op = op;
        c.request_bytes = 12'(req);
        c.release_offset = 12'(rel);
        return c;
    endfunction

    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (sb.expected_results.size() != 0 || busy);
    endtask

    task automatic send(input cmd_t c);
        int unsigned gap;
        result_t     granted;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        cmd <= c;
        do @(posedge clk); while (busy);
        granted = sb.note_command(c);
        if (c.op == OP_ALLOC && granted.status == STATUS_DONE && granted.payload_offset != 0)
            live_offsets.push_back(granted.payload_offset);
        if (c.op == OP_RELEASE) last_freed = c.release_offset;
    endtask

    task automatic write_pool(input logic [POOL_W-1:0] bytes);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= bytes;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.lay_out(bytes);
        live_offsets.delete();
        pool_now = sb.pool_limit;
    endtask

    task automatic run_random(input int unsigned count);
        cmd_t        c;
        int unsigned pick;
        int unsigned sel;
        int unsigned idx;
        for (int unsigned n = 0; n < count; n++)
        begin
            c.request_bytes = 12'($urandom);
            c.release_offset = 12'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 50 || (pick < 85 && live_offsets.size() == 0))
            begin
                c.op = OP_ALLOC;
                sel = $urandom_range(0, 19);
                if (sel < 12) c.request_bytes = 12'($urandom_range(0, pool_now / 16));
                else if (sel < 17) c.request_bytes = 12'($urandom_range(0, pool_now / 4));
                else if (sel < 19) c.request_bytes = 12'($urandom_range(0, 4095));
                else c.request_bytes = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
            end
            else if (pick < 85)
            begin
                c.op = OP_RELEASE;
                idx = $urandom_range(0, live_offsets.size() - 1);
                c.release_offset = live_offsets[idx];
                live_offsets.delete(idx);
            end
            else
            begin
                c.op = OP_RELEASE;
                sel = $urandom_range(0, 4);
                case (sel)
                    1: c.release_offset = '0;
                    2: c.release_offset = 12'($urandom_range(1, HEADER_BYTES - 1));
                    3:
                    begin
                        if (live_offsets.size() != 0)
                        begin
                            idx = $urandom_range(0, live_offsets.size() - 1);
                            c.release_offset = 12'(live_offsets[idx] + $urandom_range(1, 15));
                        end
                    end
                    4: c.release_offset = last_freed;
                    default: ;
                endcase
            end
            if ($urandom_range(0, 199) == 0) drain();
            send(c);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        cycles = 0;
        burst_left = 0;
        steady = 1'b0;
        last_freed = '0;
        pool_now = POOL_BYTES;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send(make_cmd(OP_ALLOC, 0, 4095));
        send(make_cmd(OP_ALLOC, 4095, 0));
        send(make_cmd(OP_ALLOC, 100, 0));
        send(make_cmd(OP_RELEASE, 4095, 0));
        send(make_cmd(OP_RELEASE, 0, 15));
        send(make_cmd(OP_RELEASE, 0, 4095));
        send(make_cmd(OP_RELEASE, 0, 40));
        send(make_cmd(OP_RELEASE, 0, 32));
        send(make_cmd(OP_RELEASE, 0, 32));
        send(make_cmd(OP_ALLOC, 100, 0));
        send(make_cmd(OP_RELEASE, 0, 32));
        send(make_cmd(OP_ALLOC, 90, 0));
        send(make_cmd(OP_ALLOC, 3948, 0));
        send(make_cmd(OP_ALLOC, 0, 0));
        send(make_cmd(OP_RELEASE, 0, 148));
        send(make_cmd(OP_ALLOC, 3931, 0));
        send(make_cmd(OP_ALLOC, 1, 0));
        send(make_cmd(OP_ALLOC, 0, 0));
        send(make_cmd(OP_RELEASE, 0, 4095));
        send(make_cmd(OP_ALLOC, 0, 0));
        send(make_cmd(OP_RELEASE, 0, 16));
        send(make_cmd(OP_ALLOC, 0, 0));
        write_pool(POOL_BYTES);

        run_random(700);
        write_pool(32);
        run_random(100);
        write_pool(13'h1FFF);
        steady = 1'b1;
        run_random(300);
        steady = 1'b0;
        run_random(200);
        write_pool(13'h0000);
        run_random(40);
        write_pool(POOL_W'($urandom_range(32, POOL_BYTES)));
        run_random(300);
        write_pool(POOL_BYTES);
        run_random(200);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("first_fit_heap_allocator_unit regression: pass");
        else
            $display("first_fit_heap_allocator_unit regression: fail");
        $finish;
    end

endmodule

>>> sim.f
rtl/ffha_pkg.sv
rtl/ffha_ram.sv
rtl/ffha_walk.sv
rtl/first_fit_heap_allocator_unit.sv
rtl/ffha_checker.sv
sim/tb.sv
